// ===== rtl/rgbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared constants and types of the RGB 2D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none
package rgbc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int KERNEL_MAX     = 9;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 12;
    localparam int HALF_MAX       = (KERNEL_MAX - 1) / 2;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W   = 11;
    localparam int SEL_W   = $clog2(KERNEL_MAX);
    localparam int KADDR_W = $clog2(KERNEL_MAX * KERNEL_MAX);
    localparam int PROD_W  = COEF_BITS + 9;
    localparam int ACC_W   = PROD_W + 7;
    localparam int CIDX_W  = 3;

    // operation codes
    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_HALF_R = 3'd2;
    localparam logic [CIDX_W-1:0] REG_HALF_C = 3'd3;

    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] sel;
        logic [COL_W-1:0] col;
        logic [23:0]      data;
    } t_pix_wr;

    typedef struct packed {
        logic                        en;
        logic [KADDR_W-1:0]          addr;
        logic signed [COEF_BITS-1:0] value;
    } t_coef_wr;

    typedef struct packed {
        logic [SEL_W-1:0] rmod;
        logic [DIM_W-1:0] srow;
        logic [3:0]       hr2;
        logic [DIM_W-1:0] height;
    } t_win;

    typedef struct packed {
        logic             issue;
        logic             clear;
        logic             shift;
        logic             col_ok;
        logic [COL_W-1:0] col;
        logic [3:0]       b;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] g;
        logic signed [ACC_W-1:0] bl;
    } t_acc3;

endpackage
`default_nettype wire

// ===== rtl/rgbc_pix_if.sv =====
// ----------------------------------------------------------------------------
// rgbc_pix_if
// Input item channel: operation, pixel samples and coefficient fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgbc_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [3:0]  coef_row;
    logic [3:0]  coef_col;
    logic signed [rgbc_pkg::COEF_BITS-1:0] coef_value;

    modport source (output valid, operation, red_in, green_in, blue_in,
                    coef_row, coef_col, coef_value, input ready);
    modport sink   (input valid, operation, red_in, green_in, blue_in,
                    coef_row, coef_col, coef_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbc_res_if.sv =====
// ----------------------------------------------------------------------------
// rgbc_res_if
// Result channel: filtered pixel, its position and run markers.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgbc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last_of_run;
    logic       end_of_image;

    modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                    last_of_run, end_of_image, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col,
                    last_of_run, end_of_image, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rgbc_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgbc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rgbc_pkg::CIDX_W-1:0]   index;
    logic [rgbc_pkg::DIM_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbc_cell.sv =====
// ----------------------------------------------------------------------------
// rgbc_cell
// One cell of the chain: holds one line of the row store and a copy of the
// kernel, multiplies and accumulates its kernel row, then shifts its sum on.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbc_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [rgbc_pkg::SEL_W-1:0] i_idx,
    input  wire rgbc_pkg::t_pix_wr    i_wr,
    input  wire rgbc_pkg::t_coef_wr   i_kwr,
    input  wire rgbc_pkg::t_win       i_win,
    input  wire rgbc_pkg::t_cell_ctl  i_ctl,
    input  wire rgbc_pkg::t_acc3      i_next,
    output rgbc_pkg::t_acc3           o_acc
);
    import rgbc_pkg::*;

    logic [23:0]                 r_line [MAX_WIDTH];
    logic signed [COEF_BITS-1:0] r_kmem [KERNEL_MAX*KERNEL_MAX];
    logic [KERNEL_MAX*KERNEL_MAX-1:0] r_kvalid;

    logic [4:0]         w_d;
    logic [3:0]         w_a;
    logic               w_row_ok;
    logic [KADDR_W-1:0] w_kaddr;
    logic [DIM_W-1:0]   w_rr;

    logic [23:0]                 r_pix;
    logic signed [COEF_BITS-1:0] r_coef;
    logic                        r_v1;
    logic signed [COEF_BITS-1:0] w_coef;
    logic signed [PROD_W-1:0]    r_pr, r_pg, r_pb;
    t_acc3                       r_acc;

    // kernel row served by this cell for the current window
    always_comb begin
        w_d = {1'b0, i_win.rmod} - {1'b0, i_idx};
        w_a = w_d[4] ? 4'(w_d + 5'(KERNEL_MAX)) : w_d[3:0];
        w_rr = i_win.srow - DIM_W'(w_a);
        w_row_ok = (w_a <= i_win.hr2) && (DIM_W'(w_a) <= i_win.srow) &&
                   (w_rr < i_win.height);
        w_kaddr = KADDR_W'({w_a, 3'b000}) + KADDR_W'(w_a) + KADDR_W'(i_ctl.b);
    end

    // row line store
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.sel == i_idx) begin
            r_line[i_wr.col] <= i_wr.data;
        end
        r_pix <= r_line[i_ctl.col];
    end

    // kernel copy
    always_ff @(posedge i_clk) begin
        if (i_kwr.en) begin
            r_kmem[i_kwr.addr] <= i_kwr.value;
        end
        r_coef <= r_kmem[w_kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvalid <= '0;
            r_v1     <= 1'b0;
        end else begin
            if (i_kwr.en) r_kvalid[i_kwr.addr] <= 1'b1;
            r_v1 <= i_ctl.issue && i_ctl.col_ok && w_row_ok && r_kvalid[w_kaddr];
        end
    end

    // multiply stage
    assign w_coef = r_v1 ? r_coef : '0;
    always_ff @(posedge i_clk) begin
        r_pr <= w_coef * $signed({1'b0, r_pix[7:0]});
        r_pg <= w_coef * $signed({1'b0, r_pix[15:8]});
        r_pb <= w_coef * $signed({1'b0, r_pix[23:16]});
    end

    // accumulate, or shift toward the head of the chain
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_next;
        end else begin
            r_acc.r  <= r_acc.r  + ACC_W'(r_pr);
            r_acc.g  <= r_acc.g  + ACC_W'(r_pg);
            r_acc.bl <= r_acc.bl + ACC_W'(r_pb);
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== rtl/rgb_2d_convolution_clamp.sv =====
// ----------------------------------------------------------------------------
// rgb_2d_convolution_clamp
// RGB image convolution with a flipped kernel up to 9x9, floor and clamp.
// ----------------------------------------------------------------------------
// Sequence: each output passes through the issue, wait, drain and output
//   states in that order; input is held off until the last output is taken.
// A pixel that completes no window gives no output; a row end releases up to
//   half_kernel_cols+1 outputs in sequence, all from the single chain of cells.
// Reset: synchronous active low; kernel reads as zero, scan at (0,0).
`default_nettype none
module rgb_2d_convolution_clamp (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rgbc_pix_if.sink   i_pix,
    rgbc_cfg_if.sink   i_cfg,
    rgbc_res_if.source o_res
);
    import rgbc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [DIM_W-1:0] r_width, r_height;
    logic [2:0]       r_hr, r_hc;
    logic [DIM_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [SEL_W-1:0] r_rmod;
    logic [SEL_W-1:0] r_wrmod;
    logic [DIM_W-1:0] r_wrow;
    logic [COL_W-1:0] r_orow, r_j, r_last;
    logic [3:0]       r_b, r_cnt;
    logic signed [ACC_W-1:0] r_sr, r_sg, r_sb;

    logic w_acc, w_img, w_row_end, w_have;
    logic [COL_W-1:0] w_first, w_lastc;
    logic [DIM_W-1:0] w_cfgv;
    logic [2:0]       w_half;
    logic signed [12:0] w_cc;
    t_pix_wr   w_wr;
    t_coef_wr  w_kwr;
    t_win      w_win;
    t_cell_ctl w_ctl;
    t_acc3     w_chain [KERNEL_MAX+1];

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc = i_pix.valid && i_pix.ready;

    // scan position decode
    assign w_img     = r_row < r_height;
    assign w_row_end = (DIM_W'(r_col) + 1'b1) == r_width;
    always_comb begin
        w_have  = 1'b1;
        w_first = '0;
        if (r_col >= COL_W'(r_hc)) w_first = r_col - COL_W'(r_hc);
        else if (!w_row_end) w_have = 1'b0;
        w_lastc = w_row_end ? COL_W'(r_width - 1'b1) : w_first;
        w_have  = w_have && (r_row >= DIM_W'(r_hr));
    end

    // store and kernel writes
    always_comb begin
        w_wr.en    = w_acc && (i_pix.operation == OP_PIXEL ||
                               i_pix.operation == OP_FLUSH) && w_img;
        w_wr.sel   = r_rmod;
        w_wr.col   = r_col;
        w_wr.data  = (i_pix.operation == OP_PIXEL) ?
                     {i_pix.blue_in, i_pix.green_in, i_pix.red_in} : 24'd0;
        w_kwr.en   = w_acc && i_pix.operation == OP_COEF &&
                     i_pix.coef_row < 4'(KERNEL_MAX) && i_pix.coef_col < 4'(KERNEL_MAX);
        w_kwr.addr = KADDR_W'({i_pix.coef_row, 3'b000}) + KADDR_W'(i_pix.coef_row) +
                     KADDR_W'(i_pix.coef_col);
        w_kwr.value = i_pix.coef_value;
    end

    // column issue for the current output
    always_comb begin
        w_cc = $signed({3'b000, r_j}) + $signed({10'd0, r_hc}) - $signed({9'd0, r_b});
        w_win.rmod   = r_wrmod;
        w_win.srow   = r_wrow;
        w_win.hr2    = {r_hr, 1'b0};
        w_win.height = r_height;
        w_ctl.issue  = (r_state == S_ISSUE);
        w_ctl.clear  = (r_state == S_ISSUE) && (r_b == 4'd0);
        w_ctl.shift  = (r_state == S_DRAIN);
        w_ctl.col_ok = !w_cc[12] && (w_cc < $signed({2'b00, r_width}));
        w_ctl.col    = w_cc[COL_W-1:0];
        w_ctl.b      = r_b;
    end

    // chain of cells; the tail shifts in zero
    assign w_chain[KERNEL_MAX] = '0;
    for (genvar k = 0; k < KERNEL_MAX; k++) begin : g_cell
        rgbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SEL_W'(k)),
            .i_wr    (w_wr),
            .i_kwr   (w_kwr),
            .i_win   (w_win),
            .i_ctl   (w_ctl),
            .i_next  (w_chain[k+1]),
            .o_acc   (w_chain[k])
        );
    end

    // register write value
    always_comb begin
        w_cfgv = i_cfg.data;
        w_half = (i_cfg.data[2:0] > 3'(HALF_MAX)) ? 3'(HALF_MAX) : i_cfg.data[2:0];
        if (w_cfgv == '0) w_cfgv = DIM_W'(1);
    end

    // control and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_hr     <= 3'(HALF_MAX);
            r_hc     <= 3'(HALF_MAX);
            r_row    <= '0;
            r_col    <= '0;
            r_rmod   <= '0;
            r_b      <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.index <= REG_HALF_C) begin
                unique case (i_cfg.index)
                    REG_WIDTH:  r_width  <= (w_cfgv > DIM_W'(MAX_WIDTH)) ?
                                            DIM_W'(MAX_WIDTH) : w_cfgv;
                    REG_HEIGHT: r_height <= (w_cfgv > DIM_W'(MAX_HEIGHT)) ?
                                            DIM_W'(MAX_HEIGHT) : w_cfgv;
                    REG_HALF_R: r_hr <= w_half;
                    default:    r_hc <= w_half;
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_rmod <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && (i_pix.operation == OP_PIXEL ||
                                  i_pix.operation == OP_FLUSH)) begin
                        if (w_have) begin
                            r_state <= S_ISSUE;
                            r_b     <= '0;
                        end
                        if (w_row_end || (DIM_W'(r_col) + 1'b1) > r_width) begin
                            r_col <= '0;
                            if (r_row + 1'b1 >= r_height + DIM_W'(r_hr)) begin
                                r_row  <= '0;
                                r_rmod <= '0;
                            end else begin
                                r_row  <= r_row + 1'b1;
                                r_rmod <= (r_rmod == SEL_W'(KERNEL_MAX-1)) ?
                                          '0 : r_rmod + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_ISSUE: begin
                    if (r_b == {r_hc, 1'b0}) begin
                        r_state <= S_WAIT;
                        r_cnt   <= '0;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (r_cnt == 4'd1) begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt == 4'(KERNEL_MAX-1)) r_state <= S_OUT;
                    else r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                    if (o_res.ready) begin
                        if (r_j == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            r_b     <= '0;
                        end
                    end
                end
            endcase
        end
    end

    // output context and channel sums
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc) begin
            r_wrmod <= r_rmod;
            r_wrow  <= r_row;
            r_orow  <= COL_W'(r_row - DIM_W'(r_hr));
            r_j     <= w_first;
            r_last  <= w_lastc;
        end else if (r_state == S_OUT && o_res.ready) begin
            r_j <= r_j + 1'b1;
        end
        if (w_ctl.clear) begin
            r_sr <= '0;
            r_sg <= '0;
            r_sb <= '0;
        end else if (r_state == S_DRAIN) begin
            r_sr <= r_sr + w_chain[0].r;
            r_sg <= r_sg + w_chain[0].g;
            r_sb <= r_sb + w_chain[0].bl;
        end
    end

    // floor and clamp to 0..255
    function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (s < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    assign o_res.valid        = (r_state == S_OUT);
    assign o_res.red_out      = clamp8(r_sr);
    assign o_res.green_out    = clamp8(r_sg);
    assign o_res.blue_out     = clamp8(r_sb);
    assign o_res.out_row      = r_orow;
    assign o_res.out_col      = r_j;
    assign o_res.last_of_run  = (r_j == r_last);
    assign o_res.end_of_image = ((DIM_W'(r_orow) + 1'b1) == r_height) &&
                                ((DIM_W'(r_j) + 1'b1) == r_width);
endmodule
`default_nettype wire
